FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/dru_pkg.sv
package dru_pkg;

  localparam int DEF_MAX_FIELD_BYTES = 8;
  localparam int DEF_POSITION_BITS   = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int FIELD_LANES = 8;
  localparam int LANE_BITS   = $clog2(FIELD_LANES);

  localparam logic [15:0] RUN_START_LO_POS = 16'h0020;
  localparam logic [15:0] RUN_START_HI_POS = 16'h0021;
  localparam logic [15:0] MIN_RUN_START    = 16'h0022;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0,
    KIND_END = 2'd1,
    KIND_BAD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TK_RUN,
    TK_EMPTY,
    TK_BAD
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   push;
    token_t tok;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } q_pop_t;

  typedef enum logic [1:0] {
    FP_CAPTURE,
    FP_SKIP,
    FP_FORWARD,
    FP_DONE
  } front_phase_t;

  typedef enum logic [1:0] {
    BP_HEADER,
    BP_LENGTH,
    BP_OFFSET,
    BP_DONE
  } back_phase_t;

endpackage

FILE: sv/dru_front.sv
module dru_front #(
  parameter int POSITION_BITS = dru_pkg::DEF_POSITION_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            q_full,
  input  logic [7:0]      in_attr_byte,
  input  logic            in_is_last,
  output dru_pkg::q_push_t q_push
);
  import dru_pkg::*;

  front_phase_t             phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]              start_r, start_nxt;
  logic [15:0]              start_full;
  logic                     accept;
  logic                     at_lo, at_hi, at_start, start_bad;

  assign accept     = in_valid && !q_full;
  assign at_lo      = (pos_r == POSITION_BITS'(RUN_START_LO_POS));
  assign at_hi      = (pos_r == POSITION_BITS'(RUN_START_HI_POS));
  assign at_start   = (32'(pos_r) == 32'(start_r));
  assign start_full = {in_attr_byte, start_r[7:0]};
  assign start_bad  = (start_full < MIN_RUN_START);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_is_last) begin
        phase_nxt = FP_CAPTURE;
      end else begin
        unique case (phase_r)
          FP_CAPTURE: if (at_hi) phase_nxt = start_bad ? FP_DONE : FP_SKIP;
          FP_SKIP:    if (at_start) phase_nxt = FP_FORWARD;
          FP_FORWARD: phase_nxt = FP_FORWARD;
          FP_DONE:    phase_nxt = FP_DONE;
          default:    phase_nxt = FP_CAPTURE;
        endcase
      end
    end
  end

  always_comb begin
    q_push.push     = 1'b0;
    q_push.tok.kind = TK_RUN;
    q_push.tok.data = in_attr_byte;
    q_push.tok.last = in_is_last;
    unique case (phase_r)
      FP_CAPTURE: begin
        if (at_hi && start_bad) begin
          q_push.push     = accept;
          q_push.tok.kind = TK_BAD;
        end else if (at_hi && in_is_last) begin
          q_push.push     = accept;
          q_push.tok.kind = TK_EMPTY;
        end else if (in_is_last) begin
          q_push.push     = accept;
          q_push.tok.kind = TK_BAD;
        end
      end
      FP_SKIP: begin
        if (at_start) begin
          q_push.push = accept;
        end else if (in_is_last) begin
          q_push.push     = accept;
          q_push.tok.kind = TK_EMPTY;
        end
      end
      FP_FORWARD: q_push.push = accept;
      FP_DONE:    q_push.push = 1'b0;
      default:    q_push.push = 1'b0;
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    if (accept) begin
      if (in_is_last) begin
        pos_nxt   = '0;
        start_nxt = '0;
      end else begin
        if (pos_r != '1) pos_nxt = pos_r + 1'b1;
        if (phase_r == FP_CAPTURE && at_lo) start_nxt = {start_r[15:8], in_attr_byte};
        if (phase_r == FP_CAPTURE && at_hi) start_nxt = start_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= FP_CAPTURE;
      pos_r   <= '0;
      start_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

FILE: sv/dru_queue.sv
module dru_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dru_pkg::q_push_t q_push,
  input  logic             pop,
  output logic             full,
  output dru_pkg::q_pop_t  q_pop
);
  import dru_pkg::*;

  token_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   do_push, do_pop;

  assign full        = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_pop.valid = (count_r != '0);
  assign q_pop.tok   = mem_r[rd_ptr_r];
  assign do_push     = q_push.push && !full;
  assign do_pop      = pop && q_pop.valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_push.tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: sv/dru_back.sv
module dru_back #(
  parameter int MAX_FIELD_BYTES = dru_pkg::DEF_MAX_FIELD_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dru_pkg::q_pop_t q_pop,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [63:0]     out_run_length,
  output logic signed [63:0] out_run_offset,
  output logic            out_list_end
);
  import dru_pkg::*;

  function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [3:0] cnt);
    logic [63:0] r;
    r = v;
    for (int i = 1; i < FIELD_LANES; i++) begin
      if (cnt == 4'(i) && v[8*i-1]) r = v | ({64{1'b1}} << (8*i));
    end
    return r;
  endfunction

  back_phase_t phase_r, phase_nxt;
  logic [3:0]  len_cnt_r, len_cnt_nxt, off_cnt_r, off_cnt_nxt;
  logic [3:0]  taken_r, taken_nxt, taken_inc;
  logic [63:0] len_acc_r, len_acc_nxt, off_acc_r, off_acc_nxt;
  logic [63:0] len_new, off_new;
  logic        fire, len_done, off_done, hdr_zero, hdr_bad;
  logic [3:0]  hdr_len, hdr_off;
  logic [7:0]  b;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [63:0] length_r, length_nxt, offset_r, offset_nxt;
  logic        end_r, end_nxt, emit;

  assign b         = q_pop.tok.data;
  assign fire      = q_pop.valid && (!out_valid_r || !out_stall);
  assign pop       = fire;
  assign taken_inc = taken_r + 1'b1;
  assign len_done  = (taken_inc >= len_cnt_r);
  assign off_done  = (taken_inc >= off_cnt_r);
  assign hdr_len   = b[3:0];
  assign hdr_off   = b[7:4];
  assign hdr_zero  = (b == 8'h00);
  assign hdr_bad   = (hdr_len > 4'(MAX_FIELD_BYTES)) || (hdr_off > 4'(MAX_FIELD_BYTES));

  always_comb begin
    len_new = len_acc_r;
    off_new = off_acc_r;
    for (int i = 0; i < FIELD_LANES; i++) begin
      if (taken_r[LANE_BITS-1:0] == LANE_BITS'(i)) begin
        len_new[8*i +: 8] = b;
        off_new[8*i +: 8] = b;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (q_pop.tok.kind == TK_RUN) begin
        unique case (phase_r)
          BP_HEADER: begin
            if (hdr_zero || hdr_bad) phase_nxt = BP_DONE;
            else phase_nxt = (hdr_len != '0) ? BP_LENGTH : BP_OFFSET;
          end
          BP_LENGTH: if (len_done) phase_nxt = (off_cnt_r == '0) ? BP_HEADER : BP_OFFSET;
          BP_OFFSET: if (off_done) phase_nxt = BP_HEADER;
          BP_DONE:   phase_nxt = BP_DONE;
          default:   phase_nxt = BP_HEADER;
        endcase
      end
      if (q_pop.tok.last) phase_nxt = BP_HEADER;
    end
  end

  always_comb begin
    emit        = 1'b0;
    kind_nxt    = KIND_RUN;
    length_nxt  = '0;
    offset_nxt  = '0;
    end_nxt     = 1'b0;
    len_cnt_nxt = len_cnt_r;
    off_cnt_nxt = off_cnt_r;
    taken_nxt   = taken_r;
    len_acc_nxt = len_acc_r;
    off_acc_nxt = off_acc_r;
    if (fire) begin
      unique case (q_pop.tok.kind)
        TK_BAD: begin
          emit     = 1'b1;
          kind_nxt = KIND_BAD;
          end_nxt  = 1'b1;
        end
        TK_EMPTY: begin
          emit     = 1'b1;
          kind_nxt = KIND_END;
          end_nxt  = 1'b1;
        end
        TK_RUN: begin
          unique case (phase_r)
            BP_HEADER: begin
              if (hdr_zero) begin
                emit     = 1'b1;
                kind_nxt = KIND_END;
                end_nxt  = 1'b1;
              end else if (hdr_bad) begin
                emit     = 1'b1;
                kind_nxt = KIND_BAD;
                end_nxt  = 1'b1;
              end else begin
                len_cnt_nxt = hdr_len;
                off_cnt_nxt = hdr_off;
                taken_nxt   = '0;
                len_acc_nxt = '0;
                off_acc_nxt = '0;
                emit        = q_pop.tok.last;
                end_nxt     = 1'b1;
              end
            end
            BP_LENGTH: begin
              len_acc_nxt = len_new;
              taken_nxt   = len_done ? '0 : taken_inc;
              emit        = (len_done && off_cnt_r == '0) || q_pop.tok.last;
              length_nxt  = len_new;
              end_nxt     = q_pop.tok.last;
            end
            BP_OFFSET: begin
              off_acc_nxt = off_new;
              taken_nxt   = off_done ? '0 : taken_inc;
              emit        = off_done || q_pop.tok.last;
              length_nxt  = len_acc_r;
              offset_nxt  = off_done ? sign_extend(off_new, off_cnt_r) : off_new;
              end_nxt     = q_pop.tok.last;
            end
            BP_DONE: emit = 1'b0;
            default: emit = 1'b0;
          endcase
        end
        default: emit = 1'b0;
      endcase
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= BP_HEADER;
      out_valid_r <= 1'b0;
      len_cnt_r   <= '0;
      off_cnt_r   <= '0;
      taken_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      len_cnt_r   <= len_cnt_nxt;
      off_cnt_r   <= off_cnt_nxt;
      taken_r     <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_acc_r <= len_acc_nxt;
    off_acc_r <= off_acc_nxt;
    if (emit) begin
      kind_r   <= kind_nxt;
      length_r <= length_nxt;
      offset_r <= offset_nxt;
      end_r    <= end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_run_length = length_r;
  assign out_run_offset = signed'(offset_r);
  assign out_list_end   = end_r;

endmodule

FILE: sv/data_run_list_decoder_unit.sv
// Decodes the data run list of a non-resident attribute fed one byte per transaction,
// starting at attribute offset zero. The run-list start is taken from bytes 0x20 and
// 0x21; each run then comes out as one result with its unsigned length and its
// sign-extended offset (not accumulated), and a zero header, a bad start, an oversized
// header nibble or the attribute's last byte closes the list. One byte is accepted every
// cycle while in_stall is low; each result is registered in the back end. The rate is set
// by the back end, which folds one byte per cycle into the length or offset accumulator
// unless out_stall holds a pending result. A four-entry token queue sits between the byte
// classifier and the run decoder, so in_stall rises only once the queue has filled.
module data_run_list_decoder_unit #(
  parameter int MAX_FIELD_BYTES = dru_pkg::DEF_MAX_FIELD_BYTES,
  parameter int POSITION_BITS   = dru_pkg::DEF_POSITION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_attr_byte,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [63:0]        out_run_length,
  output logic signed [63:0] out_run_offset,
  output logic               out_list_end
);
  import dru_pkg::*;

  q_push_t q_push;
  q_pop_t  q_pop;
  logic    q_full;
  logic    q_take;

  assign in_stall = q_full;

  dru_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .q_full      (q_full),
    .in_attr_byte(in_attr_byte),
    .in_is_last  (in_is_last),
    .q_push      (q_push)
  );

  dru_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_push(q_push),
    .pop   (q_take),
    .full  (q_full),
    .q_pop (q_pop)
  );

  dru_back #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_pop         (q_pop),
    .pop           (q_take),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_run_length(out_run_length),
    .out_run_offset(out_run_offset),
    .out_list_end  (out_list_end)
  );

endmodule

FILE: sv/dru_checker.sv
`include "assert_macros.svh"

module dru_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_kind,
  input logic [63:0]        out_run_length,
  input logic signed [63:0] out_run_offset,
  input logic               out_list_end
);
  import dru_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_run_length) && $stable(out_run_offset) && $stable(out_list_end))
  `ASSERT_IMPLY(a_kind_legal, clk, rst_n, out_valid, out_kind == KIND_RUN || out_kind == KIND_END || out_kind == KIND_BAD)
  `ASSERT_IMPLY(a_close_on_status, clk, rst_n, out_valid && out_kind != KIND_RUN, out_list_end)
  `ASSERT_IMPLY(a_status_zero, clk, rst_n, out_valid && out_kind != KIND_RUN, out_run_length == 64'd0 && out_run_offset == 64'sd0)

endmodule

bind data_run_list_decoder_unit dru_checker u_dru_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_run_length(out_run_length),
  .out_run_offset(out_run_offset),
  .out_list_end  (out_list_end)
);
